// File: hdl/serial_frame_receiver_assert.svh
// Assertion macros for the serial frame receiver.
`ifndef SERIAL_FRAME_RECEIVER_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SRX_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SRX_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/srx_pkg.sv
// Shared constants, types and helpers of the serial frame receiver.
package srx_pkg;

	localparam int MAX_PAYLOAD = 32;
	localparam int WIN_DEPTH   = MAX_PAYLOAD + 3;
	localparam int RAM_DEPTH   = 2 ** $clog2(WIN_DEPTH);
	localparam int PTR_W       = $clog2(RAM_DEPTH);

	localparam int BYTE_W      = 8;
	localparam int IDX_W       = 5;
	localparam int LEN_W       = 6;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;
	localparam int OUT_TDATA_W = ((BYTE_W + IDX_W + 7) / 8) * 8;

	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	localparam int OQ_DEPTH    = 4;
	localparam int OQ_PTR_W    = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W    = $clog2(OQ_DEPTH + 1) + 1;

	localparam logic [BYTE_W-1:0] HEAD_RESET = 8'hA5;
	localparam logic [BYTE_W-1:0] TAIL_RESET = 8'h5A;
	localparam logic [LEN_W-1:0]  LEN_RESET  = 6'd8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEAD = 2'd0,
		REG_TAIL = 2'd1,
		REG_LEN  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [BYTE_W-1:0] head;
		logic [BYTE_W-1:0] tail;
		logic [LEN_W-1:0]  len;   // effective length, 1..MAX_PAYLOAD
	} cfg_t;

	typedef struct packed {
		logic              en;
		logic [PTR_W-1:0]  addr;
		logic [BYTE_W-1:0] data;
	} ram_wr_t;

	typedef struct packed {
		logic [PTR_W-1:0] start;  // slot of the first payload byte
		logic [LEN_W-1:0] len;
	} desc_t;

	typedef struct packed {
		logic             busy;
		logic [PTR_W-1:0] ptr;    // oldest byte slot still to be read out
	} prot_t;

	function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
		logic [LEN_W-1:0] l;
		l = raw;
		if (raw == '0)
			l = LEN_W'(1);
		else if (raw > LEN_W'(MAX_PAYLOAD))
			l = LEN_W'(MAX_PAYLOAD);
		return l;
	endfunction

endpackage

// File: hdl/srx_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rd_data_q <= mem_q[raddr];
	end

	assign rd_data = rd_data_q;

endmodule

// File: hdl/srx_queue.sv
// Short descriptor queue between the frame finder and the payload reader.
module srx_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  srx_pkg::desc_t            push_desc,
	input  logic                      pop,
	output logic                      valid,
	output srx_pkg::desc_t            head,
	output logic [srx_pkg::QCNT_W-1:0] count
);
	import srx_pkg::*;

	desc_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q;
	logic [QPTR_W-1:0] rp_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + QPTR_W'(1);
			if (pop)
				rp_q <= rp_q + QPTR_W'(1);
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	assign valid = (cnt_q != '0);
	assign head  = mem_q[rp_q];
	assign count = cnt_q;

endmodule

// File: hdl/srx_front.sv
// Front end: takes bytes, keeps running sums, checks each full window for a frame.
module srx_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [srx_pkg::BYTE_W-1:0] s_tdata,   // [7:0] rx_byte
	input  srx_pkg::cfg_t              cfg,
	input  srx_pkg::prot_t             prot,
	input  logic [srx_pkg::QCNT_W-1:0] q_count,
	output srx_pkg::ram_wr_t           wr,
	output logic                       push,
	output srx_pkg::desc_t             push_desc
);
	import srx_pkg::*;

	logic [PTR_W-1:0]    wptr_q;
	logic [BYTE_W-1:0]   byte1_q;
	logic [BYTE_W-1:0]   ps_q;
	logic [BYTE_W-1:0]   ps1_q;
	logic [LEN_W-1:0]    fresh_q;

	logic                valid_s1;
	logic                chk_s1;
	logic [BYTE_W-1:0]   cks_s1;
	logic [BYTE_W-1:0]   ps2_s1;
	logic [PTR_W-1:0]    start_s1;

	logic                accept;
	logic [BYTE_W-1:0]   ps_new;
	logic [PTR_W-1:0]    head_addr;
	logic [2*BYTE_W-1:0] win_rd;
	logic                frame_ok;
	logic [LEN_W-1:0]    flen;
	logic [LEN_W-1:0]    fresh_base;
	logic [LEN_W-1:0]    fresh_inc;
	logic                chk;
	logic                q_block;
	logic                clobber;

	// ps_q holds the wrapping sum of all bytes up to the newest one; the
	// payload sum is the difference of two such prefix sums.
	assign ps_new    = ps_q + s_tdata;
	assign head_addr = wptr_q - PTR_W'(cfg.len) - PTR_W'(2);

	srx_ram #(
		.WIDTH(2 * BYTE_W),
		.DEPTH(RAM_DEPTH)
	) u_win_ram (
		.clk    (clk),
		.we     (accept),
		.waddr  (wptr_q),
		.wdata  ({ps_new, s_tdata}),
		.raddr  (head_addr),
		.rd_data(win_rd)
	);

	assign frame_ok = valid_s1 && chk_s1 && (win_rd[BYTE_W-1:0] == cfg.head)
		&& (cks_s1 == ps2_s1 - win_rd[2*BYTE_W-1:BYTE_W]);

	// a frame found in s1 consumes the window before this byte counts
	assign flen       = cfg.len + LEN_W'(3);
	assign fresh_base = frame_ok ? '0 : fresh_q;
	assign fresh_inc  = (fresh_base >= flen) ? flen : fresh_base + LEN_W'(1);
	assign chk        = (fresh_inc == flen);

	assign q_block = (q_count == QCNT_W'(QDEPTH))
		|| ((q_count == QCNT_W'(QDEPTH - 1)) && valid_s1 && chk_s1);
	assign clobber = prot.busy && (wptr_q == prot.ptr);

	assign s_tready = !q_block && !clobber;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q   <= '0;
			byte1_q  <= '0;
			ps_q     <= '0;
			ps1_q    <= '0;
			fresh_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				wptr_q  <= wptr_q + PTR_W'(1);
				byte1_q <= s_tdata;
				ps_q    <= ps_new;
				ps1_q   <= ps_q;
				fresh_q <= fresh_inc;
			end else if (frame_ok) begin
				fresh_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			chk_s1   <= chk && (s_tdata == cfg.tail);
			cks_s1   <= byte1_q;
			ps2_s1   <= ps1_q;
			start_s1 <= wptr_q - PTR_W'(cfg.len) - PTR_W'(1);
		end
	end

	assign wr.en   = accept;
	assign wr.addr = wptr_q;
	assign wr.data = s_tdata;

	assign push            = frame_ok;
	assign push_desc.start = start_s1;
	assign push_desc.len   = cfg.len;

endmodule

// File: hdl/srx_back.sv
// Back end: reads payload bytes of found frames out of the byte store.
module srx_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  srx_pkg::ram_wr_t                wr,
	input  logic                            q_valid,
	input  srx_pkg::desc_t                  q_head,
	output logic                            q_pop,
	output srx_pkg::prot_t                  stat,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [srx_pkg::OUT_TDATA_W-1:0] m_tdata,  // [7:0] payload_byte, [12:8] byte_index
	output logic                            m_tlast
);
	import srx_pkg::*;

	logic                busy_q;
	logic [PTR_W-1:0]    rd_q;
	logic [IDX_W-1:0]    idx_q;
	logic [LEN_W-1:0]    len_q;

	logic                inflight_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic                last_s1;

	logic [BYTE_W-1:0]   oq_byte_q [OQ_DEPTH];
	logic [IDX_W-1:0]    oq_idx_q  [OQ_DEPTH];
	logic                oq_last_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] oq_wp_q;
	logic [OQ_PTR_W-1:0] oq_rp_q;
	logic [OQ_CNT_W-1:0] oq_cnt_q;

	logic [BYTE_W-1:0]   ram_byte;
	logic                credit;
	logic                issue;
	logic                last_now;
	logic                out_xfer;

	srx_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(RAM_DEPTH)
	) u_byte_ram (
		.clk    (clk),
		.we     (wr.en),
		.waddr  (wr.addr),
		.wdata  (wr.data),
		.raddr  (rd_q),
		.rd_data(ram_byte)
	);

	// reads in flight count against output queue room
	assign credit   = (oq_cnt_q + OQ_CNT_W'(inflight_s1)) < OQ_CNT_W'(OQ_DEPTH);
	assign issue    = busy_q && credit;
	assign last_now = (idx_q == IDX_W'(len_q - LEN_W'(1)));
	assign q_pop    = !busy_q && q_valid;
	assign out_xfer = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rd_q        <= '0;
			inflight_s1 <= 1'b0;
			oq_wp_q     <= '0;
			oq_rp_q     <= '0;
			oq_cnt_q    <= '0;
		end else begin
			inflight_s1 <= issue;
			if (q_pop) begin
				busy_q <= 1'b1;
				rd_q   <= q_head.start;
			end else if (issue) begin
				rd_q <= rd_q + PTR_W'(1);
				if (last_now)
					busy_q <= 1'b0;
			end
			if (inflight_s1)
				oq_wp_q <= oq_wp_q + OQ_PTR_W'(1);
			if (out_xfer)
				oq_rp_q <= oq_rp_q + OQ_PTR_W'(1);
			oq_cnt_q <= oq_cnt_q + OQ_CNT_W'(inflight_s1) - OQ_CNT_W'(out_xfer);
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			idx_q <= '0;
			len_q <= q_head.len;
		end else if (issue) begin
			idx_q <= idx_q + IDX_W'(1);
		end
		if (issue) begin
			idx_s1  <= idx_q;
			last_s1 <= last_now;
		end
		if (inflight_s1) begin
			oq_byte_q[oq_wp_q] <= ram_byte;
			oq_idx_q[oq_wp_q]  <= idx_s1;
			oq_last_q[oq_wp_q] <= last_s1;
		end
	end

	assign stat.busy = busy_q;
	assign stat.ptr  = rd_q;

	assign m_tvalid = (oq_cnt_q != '0);
	assign m_tdata  = {{(OUT_TDATA_W - IDX_W - BYTE_W){1'b0}},
		oq_idx_q[oq_rp_q], oq_byte_q[oq_rp_q]};
	assign m_tlast  = oq_last_q[oq_rp_q];

endmodule

// File: hdl/serial_frame_receiver.sv
// Serial frame receiver: takes one byte per cycle unless stalled, emits the payload of each valid frame.
// Throughput: one input byte per cycle unless stalled; one payload byte per cycle out while the sink is ready.
// The reader pauses between frames to load the next one; a payload byte passes the byte store and output queue.
// Input stalls only when the byte store would overwrite payload not yet read out,
// or the frame queue is full or down to one slot while a frame check is pending.
// Reset (arst_n low, asynchronous): registers to defaults, window empty, queues drained.
module serial_frame_receiver (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [srx_pkg::BYTE_W-1:0]         s_tdata,    // [7:0] rx_byte
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [srx_pkg::OUT_TDATA_W-1:0]    m_tdata,    // [7:0] payload_byte, [12:8] byte_index
	output logic                               m_tlast,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [srx_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [srx_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import srx_pkg::*;

`include "serial_frame_receiver_assert.svh"

	logic [BYTE_W-1:0] head_q;
	logic [BYTE_W-1:0] tail_q;
	logic [LEN_W-1:0]  len_q;

	cfg_t              cfg;
	ram_wr_t           wr;
	prot_t             prot;
	prot_t             stat;
	desc_t             push_desc;
	desc_t             q_head;
	logic              q_push;
	logic              q_pop;
	logic              q_valid;
	logic [QCNT_W-1:0] q_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= HEAD_RESET;
			tail_q <= TAIL_RESET;
			len_q  <= LEN_RESET;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_HEAD: head_q <= cfg_data[BYTE_W-1:0];
				REG_TAIL: tail_q <= cfg_data[BYTE_W-1:0];
				REG_LEN:  len_q  <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.head = head_q;
	assign cfg.tail = tail_q;
	assign cfg.len  = eff_len(len_q);

	// oldest payload slot that must survive until it is read out
	assign prot.busy = stat.busy || q_valid;
	assign prot.ptr  = stat.busy ? stat.ptr : q_head.start;

	srx_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.cfg      (cfg),
		.prot     (prot),
		.q_count  (q_count),
		.wr       (wr),
		.push     (q_push),
		.push_desc(push_desc)
	);

	srx_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_desc(push_desc),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (q_head),
		.count    (q_count)
	);

	srx_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.stat    (stat),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	`SRX_ASSERT_NOW(a_queue_room, q_push, q_count != QCNT_W'(QDEPTH), "frame pushed into full queue")
	`SRX_ASSERT_NOW(a_no_clobber, wr.en && prot.busy, wr.addr != prot.ptr, "unread payload overwritten")
	`SRX_ASSERT_NEXT(a_frame_load, q_pop, stat.busy, "reader did not start on popped frame")

endmodule

// File: sim/serial_frame_receiver_tb.sv
// Self-checking testbench for the serial frame receiver: directed table, then random frames.
module serial_frame_receiver_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import srx_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;  // no register behind this index
	localparam int DRAIN_CYCLES   = 16;
	localparam int HOLD_CYCLES    = 300;
	localparam int PHASE_BYTES    = 6;
	localparam int PRESSURE_BYTES = 40;
	localparam int N_PHASES       = 6;

	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic [IDX_W-1:0]  pos;
		logic              is_last;
	} frame_byte_t;

	// ROW_RX is checked against the predictor, the other receive rows carry their own expectation
	typedef enum logic [1:0] {ROW_CFG, ROW_RX, ROW_RX_NONE, ROW_RX_ONE} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [CFG_IDX_W-1:0] reg_index;
		logic [7:0]        value;
		logic [7:0]        single_payload;  // sole payload byte of a one-byte frame
	} stim_row_t;

	localparam int N_ROWS = 34;
	localparam stim_row_t DIRECTED [N_ROWS] = '{
		// zeros left by reset must not form a frame
		'{ROW_CFG,     REG_HEAD, 8'h00, 8'h00},
		'{ROW_CFG,     REG_TAIL, 8'h00, 8'h00},
		'{ROW_CFG,     REG_LEN,  8'h00, 8'h00},  // length zero acts as one
		'{ROW_RX_NONE, '0,       8'h00, 8'h00},
		'{ROW_CFG,     REG_HEAD, 8'hA5, 8'h00},
		'{ROW_CFG,     REG_TAIL, 8'h5A, 8'h00},
		'{ROW_RX_NONE, '0,       8'hA5, 8'h00},
		'{ROW_RX_NONE, '0,       8'hFF, 8'h00},
		'{ROW_RX_NONE, '0,       8'hFF, 8'h00},
		'{ROW_RX_ONE,  '0,       8'h5A, 8'hFF},
		// checksum off by one
		'{ROW_RX_NONE, '0,       8'hA5, 8'h00},
		'{ROW_RX_NONE, '0,       8'h10, 8'h00},
		'{ROW_RX_NONE, '0,       8'h11, 8'h00},
		'{ROW_RX_NONE, '0,       8'h5A, 8'h00},
		'{ROW_CFG,     REG_HEAD, 8'h00, 8'h00},
		'{ROW_CFG,     REG_TAIL, 8'hFF, 8'h00},
		'{ROW_CFG,     REG_LEN,  8'hC2, 8'h00},  // upper bits dropped, length 2
		'{ROW_RX,      '0,       8'h00, 8'h00},
		'{ROW_RX,      '0,       8'h80, 8'h00},
		'{ROW_RX,      '0,       8'h7F, 8'h00},
		'{ROW_RX,      '0,       8'hFF, 8'h00},
		'{ROW_RX,      '0,       8'hFF, 8'h00},
		'{ROW_CFG,     REG_UNUSED, 8'h12, 8'h00},
		// checksum wraps
		'{ROW_RX,      '0,       8'h00, 8'h00},
		'{ROW_RX,      '0,       8'hF0, 8'h00},
		'{ROW_RX,      '0,       8'h20, 8'h00},
		'{ROW_RX,      '0,       8'h10, 8'h00},
		'{ROW_RX,      '0,       8'hFF, 8'h00},
		// four unused bytes, then a shorter length clamps the count and checks at once
		'{ROW_RX_NONE, '0,       8'h44, 8'h00},
		'{ROW_RX_NONE, '0,       8'h00, 8'h00},
		'{ROW_RX_NONE, '0,       8'h33, 8'h00},
		'{ROW_RX_NONE, '0,       8'h33, 8'h00},
		'{ROW_CFG,     REG_LEN,  8'h01, 8'h00},
		'{ROW_RX_ONE,  '0,       8'hFF, 8'h33}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [BYTE_W-1:0]      s_tdata;    // [7:0] rx_byte
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;    // [7:0] payload_byte, [12:8] byte_index
	logic                   m_tlast;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// deframer mirror
	logic [7:0]  win_bytes [WIN_DEPTH];
	int unsigned unused_bytes;
	logic [7:0]  head_val;
	logic [7:0]  tail_val;
	logic [5:0]  len_raw;
	frame_byte_t step_results[$];
	frame_byte_t expected_payload[$];

	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_seq = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	serial_frame_receiver u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	function automatic int unsigned frame_payload_len();
		int unsigned l;
		l = len_raw;
		if (l == 0)
			l = 1;
		else if (l > MAX_PAYLOAD)
			l = MAX_PAYLOAD;
		return l;
	endfunction

	// Shift one byte into the window; leaves the payload of a found frame in step_results.
	function automatic void deframe_step(input logic [7:0] rx);
		int unsigned l;
		int unsigned f;
		int unsigned i;
		logic [7:0]  sum;
		l = frame_payload_len();
		f = l + 3;
		step_results.delete();
		for (i = WIN_DEPTH - 1; i > 0; i--)
			win_bytes[i] = win_bytes[i-1];
		win_bytes[0] = rx;
		unused_bytes = (unused_bytes + 1 > f) ? f : unused_bytes + 1;
		if (unused_bytes < f)
			return;
		sum = '0;
		for (i = 0; i < l; i++)
			sum += win_bytes[f-2-i];
		if (win_bytes[f-1] != head_val || win_bytes[0] != tail_val || win_bytes[1] != sum)
			return;
		for (i = 0; i < l; i++)
			step_results.push_back(frame_byte_t'{win_bytes[f-2-i], IDX_W'(i), i == l - 1});
		unused_bytes = 0;
	endfunction

	// All stimulus tasks start and end at a falling edge.
	task automatic send_rx(input logic [7:0] b);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		deframe_step(b);
		@(negedge clk);
	endtask

	task automatic send_predicted(input logic [7:0] b);
		send_rx(b);
		foreach (step_results[k])
			expected_payload.push_back(step_results[k]);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		s_tvalid <= 1'b0;
		while (expected_payload.size() != 0)
			@(negedge clk);
		// a check may still be in flight without any result
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_HEAD: head_val = val;
			REG_TAIL: tail_val = val;
			REG_LEN:  len_raw = val[LEN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly well-formed frames, some with a corrupted head, checksum or tail, some noise.
	task automatic random_phase(input int target);
		int         sent;
		int         k;
		int         l;
		int         pick;
		int         bad;
		logic [7:0] sum;
		logic [7:0] burst[$];
		sent = 0;
		while (sent < target) begin
			burst.delete();
			pick = $urandom_range(99);
			l = frame_payload_len();
			if (pick < 85) begin
				burst.push_back(head_val);
				sum = '0;
				for (k = 0; k < l; k++) begin
					burst.push_back(8'($urandom_range(255)));
					sum += burst[k+1];
				end
				burst.push_back(sum);
				burst.push_back(tail_val);
				if (pick >= 70) begin
					case ($urandom_range(2))
						0: bad = 0;
						1: bad = l + 1;
						default: bad = l + 2;
					endcase
					burst[bad] ^= 8'($urandom_range(1, 255));
				end
			end else begin
				for (k = $urandom_range(1, 3); k > 0; k--)
					burst.push_back(8'($urandom_range(255)));
			end
			foreach (burst[j])
				send_predicted(burst[j]);
			sent += burst.size();
		end
	endtask

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int seen_seq;
		int hold_left;
		m_tready = 1'b0;
		seen_seq = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_seq != seen_seq) begin
				seen_seq = hold_seq;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else
				m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		frame_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_payload.size() == 0) begin
				errors++;
				$error("unexpected payload transfer: payload_byte %02h byte_index %0d last %0b",
					m_tdata[BYTE_W-1:0], m_tdata[BYTE_W+IDX_W-1:BYTE_W], m_tlast);
			end else begin
				want = expected_payload.pop_front();
				if (m_tdata[BYTE_W-1:0] !== want.value) begin
					errors++;
					$error("payload_byte: expected %02h, got %02h", want.value, m_tdata[BYTE_W-1:0]);
				end
				if (m_tdata[BYTE_W+IDX_W-1:BYTE_W] !== want.pos) begin
					errors++;
					$error("byte_index: expected %0d, got %0d", want.pos,
						m_tdata[BYTE_W+IDX_W-1:BYTE_W]);
				end
				if (m_tlast !== want.is_last) begin
					errors++;
					$error("last: expected %0b, got %0b", want.is_last, m_tlast);
				end
			end
		end
	end

	initial begin
		int r;
		int p;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_HEAD;
		cfg_data  = '0;
		head_val  = HEAD_RESET;
		tail_val  = TAIL_RESET;
		len_raw   = LEN_RESET;
		unused_bytes = 0;
		foreach (win_bytes[i])
			win_bytes[i] = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (r = 0; r < N_ROWS; r++) begin
			case (DIRECTED[r].kind)
				ROW_CFG: write_reg(DIRECTED[r].reg_index, DIRECTED[r].value);
				ROW_RX: send_predicted(DIRECTED[r].value);
				ROW_RX_NONE: send_rx(DIRECTED[r].value);
				ROW_RX_ONE: begin
					send_rx(DIRECTED[r].value);
					expected_payload.push_back(
						frame_byte_t'{DIRECTED[r].single_payload, '0, 1'b1});
				end
			endcase
		end

		for (p = 0; p < N_PHASES; p++) begin
			send_idle_pct = 0;
			recv_stall_pct = 0;
			case (p)
				0: begin
					write_reg(REG_HEAD, 8'($urandom_range(255)));
					write_reg(REG_TAIL, 8'($urandom_range(255)));
					write_reg(REG_LEN, 8'd3);
				end
				1: begin
					write_reg(REG_HEAD, 8'hFF);
					write_reg(REG_TAIL, 8'h00);
					write_reg(REG_LEN, 8'h7F);  // above the maximum, acts as 32
					send_idle_pct = 72;
				end
				2: begin
					write_reg(REG_HEAD, 8'($urandom_range(255)));
					write_reg(REG_TAIL, 8'($urandom_range(255)));
					write_reg(REG_LEN, 8'($urandom_range(1, 8)));
					recv_stall_pct = 72;
				end
				3: begin
					write_reg(REG_LEN, 8'($urandom_range(0, 6)));
					send_idle_pct = 37;
					recv_stall_pct = 37;
				end
				4: begin
					// sink held off while the source keeps offering, so the input backs up
					write_reg(REG_HEAD, 8'hA5);
					write_reg(REG_TAIL, 8'h5A);
					write_reg(REG_LEN, 8'd4);
					hold_seq++;
				end
				default: begin
					write_reg(REG_HEAD, 8'($urandom_range(255)));
					write_reg(REG_TAIL, 8'($urandom_range(255)));
					write_reg(REG_LEN, 8'($urandom_range(1, 6)));
				end
			endcase
			random_phase((p == 4) ? PRESSURE_BYTES : PHASE_BYTES);
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		s_tvalid <= 1'b0;
		while (expected_payload.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && expected_payload.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
